// ===== sv/sicag_pkg.sv =====
// Package for the strided index-copy address generator.
// Holds field widths, divider step, register indexes, reset value and status codes; no dependencies.
`timescale 1ns / 1ps

package sicag_pkg;

	// Fixed field widths of the item and result transfers.
	localparam int SLICE_BITS  = 16;
	localparam int INDEX_BITS  = 64;
	localparam int ELEM_BITS   = 48;
	localparam int VALUE_BITS  = 64;
	localparam int OFF_BITS    = 35;
	localparam int PACKED_BITS = 64;
	localparam int DEXT_BITS   = 16;

	// Divider resolves this many quotient bits per pipeline stage.
	localparam int STEP_BITS  = 4;
	localparam int DIV_STAGES = ELEM_BITS / STEP_BITS;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RANK        = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SEL_DIM     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EXTENTS     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_STRIDES = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DST_STRIDES = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DST_EXTENT  = 3'd5;

	// Reset value of the packed extents: every extent one.
	localparam logic [PACKED_BITS-1:0] EXTENTS_RESET = 64'h0001_0001_0001_0001;

	// Result status codes.
	localparam logic [1:0] ST_WRITE   = 2'd0;
	localparam logic [1:0] ST_SKIP    = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;

endpackage

// ===== sv/sicag_delay.sv =====
// Fixed-length shift line that delays a data word by a number of cycles.
// Depends on nothing; valid tracking is done by the instantiating module.
`timescale 1ns / 1ps

module sicag_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_sn [N];

	// Each tap takes the word from the tap before it.
	always_ff @(posedge clk) begin
		tap_sn[0] <= din;
		for (int i = 1; i < N; i++) begin
			tap_sn[i] <= tap_sn[i-1];
		end
	end

	assign dout = tap_sn[N-1];

endmodule

// ===== sv/sicag_divider.sv =====
// Pipelined restoring divider: element number by one extent.
// Depends on sicag_pkg for the dividend width and bits per stage.
`timescale 1ns / 1ps

module sicag_divider import sicag_pkg::*; #(
	parameter int EB = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [ELEM_BITS-1:0] dividend,
	input  logic [EB-1:0]        divisor,
	output logic                 out_valid,
	output logic [ELEM_BITS-1:0] quotient,
	output logic [EB-1:0]        remainder
);

	localparam int DW = EB + ELEM_BITS;

	logic [DIV_STAGES-1:0] vld_sn;
	logic [ELEM_BITS-1:0]  work_sn [DIV_STAGES];
	logic [EB-1:0]         part_sn [DIV_STAGES];
	logic [DW-1:0]         next_c  [DIV_STAGES];

	// STEP_BITS steps of shift, compare and subtract; the quotient bits fill the
	// work word from the bottom as the dividend bits leave at the top.
	function automatic logic [DW-1:0] div_steps(input logic [EB-1:0] p_in,
			input logic [ELEM_BITS-1:0] w_in, input logic [EB-1:0] dvs);
		logic [EB:0]          t;
		logic [EB-1:0]        p;
		logic [ELEM_BITS-1:0] w;
		p = p_in;
		w = w_in;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {p, w[ELEM_BITS-1]};
			w = {w[ELEM_BITS-2:0], 1'b0};
			if (t >= {1'b0, dvs}) begin
				t = t - {1'b0, dvs};
				w[0] = 1'b1;
			end
			p = t[EB-1:0];
		end
		return {p, w};
	endfunction

	// Step logic in front of each stage.
	always_comb begin
		next_c[0] = div_steps('0, dividend, divisor);
		for (int s = 1; s < DIV_STAGES; s++) begin
			next_c[s] = div_steps(part_sn[s-1], work_sn[s-1], divisor);
		end
	end

	// Valid bits travel with the partial results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else begin
			vld_sn <= {vld_sn[DIV_STAGES-2:0], in_valid};
		end
	end

	// Partial remainder and work word registers.
	always_ff @(posedge clk) begin
		for (int s = 0; s < DIV_STAGES; s++) begin
			part_sn[s] <= next_c[s][DW-1:ELEM_BITS];
			work_sn[s] <= next_c[s][ELEM_BITS-1:0];
		end
	end

	assign out_valid = vld_sn[DIV_STAGES-1];
	assign quotient  = work_sn[DIV_STAGES-1];
	assign remainder = part_sn[DIV_STAGES-1];

endmodule

// ===== sv/sicag_dot.sv =====
// Two-stage signed dot product of coordinates with strides.
// Depends on sicag_pkg for the offset width; sums wrap at that width.
`timescale 1ns / 1ps

module sicag_dot import sicag_pkg::*; #(
	parameter int N  = 4,
	parameter int CW = 16,
	parameter int SB = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [N-1:0][CW-1:0]   coords,
	input  logic [N-1:0][SB-1:0]   strides,
	input  logic [N-1:0]           mask,
	output logic                   out_valid,
	output logic [OFF_BITS-1:0]    sum
);

	localparam int PW = CW + 1 + SB;

	logic signed [PW-1:0]  prod_c  [N];
	logic [OFF_BITS-1:0]   prod_s1 [N];
	logic [OFF_BITS-1:0]   sum_c;
	logic                  v_s1;
	logic                  v_s2;
	logic [OFF_BITS-1:0]   sum_s2;

	// One multiplier per dimension; unused dimensions give zero.
	always_comb begin
		for (int k = 0; k < N; k++) begin
			prod_c[k] = signed'({1'b0, coords[k]}) * signed'(strides[k]);
		end
	end

	// Adder over the registered products.
	always_comb begin
		sum_c = '0;
		for (int k = 0; k < N; k++) begin
			sum_c = sum_c + prod_s1[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			prod_s1[k] <= mask[k] ? OFF_BITS'(prod_c[k]) : '0;
		end
		sum_s2 <= sum_c;
	end

	assign out_valid = v_s2;
	assign sum       = sum_s2;

endmodule

// ===== sv/strided_index_copy_address_gen.sv =====
// Strided index-copy address generator, top level.
// Depends on sicag_pkg, sicag_delay, sicag_divider and sicag_dot.
//
// Usage: an item transfer happens on a clock edge with start high and busy
// low; busy is always low, so one item may enter in every cycle. Each item
// gives exactly one result, shown on the result ports for one cycle with
// done high. On its way the item passes one capture stage, twelve divider
// stages per dimension resolving four quotient bits each, two dot-product
// stages and one output register. Throughput is one item per cycle, set by
// the fully pipelined divider chain. The receiver cannot stall, so nothing
// ever backs up. Configuration writes use cfg_valid and cfg_ready (always
// high); the user must make them only while no item is in flight, as the
// block does not enforce it. Reset clears the valid bits and loads the
// register reset values: rank one, selected dimension zero, all extents
// one, strides zero and a target extent of zero.
`timescale 1ns / 1ps

module strided_index_copy_address_gen import sicag_pkg::*; #(
	parameter int MAX_RANK    = 4,
	parameter int EXTENT_BITS = 16,
	parameter int STRIDE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [SLICE_BITS-1:0]   src_slice,
	input  logic signed [INDEX_BITS-1:0] index_value,
	input  logic [ELEM_BITS-1:0]    elem_num,
	input  logic [VALUE_BITS-1:0]   elem_value,
	output logic                    done,
	output logic signed [OFF_BITS-1:0] src_offset,
	output logic signed [OFF_BITS-1:0] dst_offset,
	output logic [VALUE_BITS-1:0]   copied_value,
	output logic [1:0]              status,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [PACKED_BITS-1:0]  cfg_data
);

	localparam int RW     = $clog2(MAX_RANK + 1);
	localparam int CW     = (EXTENT_BITS > SLICE_BITS) ? EXTENT_BITS : SLICE_BITS;
	localparam int CHAIN  = MAX_RANK * DIV_STAGES;
	localparam int SIDE_W = SLICE_BITS + 1 + SLICE_BITS + 1 + VALUE_BITS;
	localparam int FIN_W  = 2 + VALUE_BITS;
	localparam int LAT    = CHAIN + 4;

	// Configuration registers.
	logic [2:0]             rank_q;
	logic [1:0]             sel_dim_q;
	logic [PACKED_BITS-1:0] extents_q;
	logic [PACKED_BITS-1:0] src_str_q;
	logic [PACKED_BITS-1:0] dst_str_q;
	logic [DEXT_BITS-1:0]   dst_ext_q;

	logic [RW-1:0]                            r_eff;
	logic [MAX_RANK-1:0][EXTENT_BITS-1:0]     ext;
	logic [MAX_RANK-1:0][STRIDE_BITS-1:0]     sstr;
	logic [MAX_RANK-1:0][STRIDE_BITS-1:0]     dstr;
	logic [MAX_RANK-1:0]                      in_rank;
	logic [MAX_RANK-1:0]                      div_dim;
	logic [EXTENT_BITS-1:0]                   ext_sel;
	logic                                     zero_ext;
	logic                                     outside_c;
	logic                                     idx_bad_c;

	// Capture stage.
	logic                    v_s1;
	logic [SLICE_BITS-1:0]   slice_s1;
	logic [SLICE_BITS-1:0]   idx_lo_s1;
	logic                    idx_bad_s1;
	logic                    outside_s1;
	logic [ELEM_BITS-1:0]    rem_s1;
	logic [VALUE_BITS-1:0]   elem_s1;

	// Divider chain.
	logic [MAX_RANK-1:0]      grp_v;
	logic [ELEM_BITS-1:0]     grp_q   [MAX_RANK];
	logic [EXTENT_BITS-1:0]   grp_r   [MAX_RANK];
	logic [EXTENT_BITS-1:0]   grp_dvs [MAX_RANK];
	logic [EXTENT_BITS-1:0]   coord_div [MAX_RANK];

	logic [SIDE_W-1:0]        side_d;
	logic [SLICE_BITS-1:0]    slice_c;
	logic                     idx_bad_d;
	logic [SLICE_BITS-1:0]    idx_lo_c;
	logic                     outside_d;
	logic [VALUE_BITS-1:0]    elem_c;
	logic                     outside_e;

	logic [MAX_RANK-1:0][CW-1:0] src_coord;
	logic [MAX_RANK-1:0][CW-1:0] dst_coord;

	logic                     src_v;
	logic                     dst_v;
	logic [OFF_BITS-1:0]      src_sum;
	logic [OFF_BITS-1:0]      dst_sum;
	logic [FIN_W-1:0]         fin_d;

	// Output register.
	logic                     done_q;
	logic [OFF_BITS-1:0]      src_off_q;
	logic [OFF_BITS-1:0]      dst_off_q;
	logic [VALUE_BITS-1:0]    value_q;
	logic [1:0]               status_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q    <= 3'd1;
			sel_dim_q <= '0;
			extents_q <= EXTENTS_RESET;
			src_str_q <= '0;
			dst_str_q <= '0;
			dst_ext_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RANK:        rank_q    <= cfg_data[2:0];
				CFG_SEL_DIM:     sel_dim_q <= cfg_data[1:0];
				CFG_EXTENTS:     extents_q <= cfg_data;
				CFG_SRC_STRIDES: src_str_q <= cfg_data;
				CFG_DST_STRIDES: dst_str_q <= cfg_data;
				CFG_DST_EXTENT:  dst_ext_q <= cfg_data[DEXT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Rank in use, clamped to the supported range.
	always_comb begin
		if (rank_q == 3'd0) begin
			r_eff = RW'(1);
		end else if (int'(rank_q) > MAX_RANK) begin
			r_eff = RW'(MAX_RANK);
		end else begin
			r_eff = RW'(rank_q);
		end
	end

	// Unpack per-dimension extents and strides; fields past bit 63 are zero.
	for (genvar d = 0; d < MAX_RANK; d++) begin : g_unpack
		if (d * EXTENT_BITS < PACKED_BITS) begin : g_ext
			assign ext[d] = EXTENT_BITS'(extents_q >> (d * EXTENT_BITS));
		end else begin : g_ext_none
			assign ext[d] = '0;
		end
		if (d * STRIDE_BITS < PACKED_BITS) begin : g_str
			assign sstr[d] = STRIDE_BITS'(src_str_q >> (d * STRIDE_BITS));
			assign dstr[d] = STRIDE_BITS'(dst_str_q >> (d * STRIDE_BITS));
		end else begin : g_str_none
			assign sstr[d] = '0;
			assign dstr[d] = '0;
		end
		assign in_rank[d] = (d < int'(r_eff));
		assign div_dim[d] = in_rank[d] && (d != int'(sel_dim_q));
	end

	// Checks made at capture: selected dimension, slice, zero extents and target index.
	always_comb begin
		ext_sel  = '0;
		zero_ext = 1'b0;
		for (int d = 0; d < MAX_RANK; d++) begin
			if (d == int'(sel_dim_q)) begin
				ext_sel = ext[d];
			end
			if (div_dim[d] && ext[d] == '0) begin
				zero_ext = 1'b1;
			end
		end
		outside_c = (int'(sel_dim_q) >= int'(r_eff)) || (src_slice >= ext_sel) || zero_ext;
		idx_bad_c = index_value[INDEX_BITS-1] ||
			(index_value >= signed'({1'b0, (INDEX_BITS-1)'(dst_ext_q)}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		slice_s1   <= src_slice;
		idx_lo_s1  <= index_value[SLICE_BITS-1:0];
		idx_bad_s1 <= idx_bad_c;
		outside_s1 <= outside_c;
		rem_s1     <= elem_num;
		elem_s1    <= elem_value;
	end

	// Divider groups, last dimension first; a dimension that takes no part
	// divides by one so the element number passes unchanged.
	for (genvar g = 0; g < MAX_RANK; g++) begin : g_div
		localparam int D  = MAX_RANK - 1 - g;
		localparam int DL = (MAX_RANK - 1 - g) * DIV_STAGES;

		assign grp_dvs[g] = (div_dim[D] && ext[D] != '0) ? ext[D] : EXTENT_BITS'(1);

		if (g == 0) begin : g_first
			sicag_divider #(.EB(EXTENT_BITS)) u_div (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (v_s1),
				.dividend  (rem_s1),
				.divisor   (grp_dvs[g]),
				.out_valid (grp_v[g]),
				.quotient  (grp_q[g]),
				.remainder (grp_r[g])
			);
		end else begin : g_next
			sicag_divider #(.EB(EXTENT_BITS)) u_div (
				.clk       (clk),
				.arst_n    (arst_n),
				.in_valid  (grp_v[g-1]),
				.dividend  (grp_q[g-1]),
				.divisor   (grp_dvs[g]),
				.out_valid (grp_v[g]),
				.quotient  (grp_q[g]),
				.remainder (grp_r[g])
			);
		end

		// Line the coordinate up with the end of the chain.
		if (DL > 0) begin : g_dly
			sicag_delay #(.W(EXTENT_BITS), .N(DL)) u_cdly (
				.clk  (clk),
				.din  (grp_r[g]),
				.dout (coord_div[D])
			);
		end else begin : g_nodly
			assign coord_div[D] = grp_r[g];
		end
	end

	// Item fields that ride alongside the divider chain.
	sicag_delay #(.W(SIDE_W), .N(CHAIN)) u_side (
		.clk  (clk),
		.din  ({slice_s1, idx_bad_s1, idx_lo_s1, outside_s1, elem_s1}),
		.dout (side_d)
	);

	assign {slice_c, idx_bad_d, idx_lo_c, outside_d, elem_c} = side_d;
	assign outside_e = outside_d || (grp_q[MAX_RANK-1] != '0);

	// Coordinates with the selected one replaced by slice or index.
	for (genvar d = 0; d < MAX_RANK; d++) begin : g_coord
		assign src_coord[d] = (d == int'(sel_dim_q)) ? CW'(slice_c)  : CW'(coord_div[d]);
		assign dst_coord[d] = (d == int'(sel_dim_q)) ? CW'(idx_lo_c) : CW'(coord_div[d]);
	end

	sicag_dot #(.N(MAX_RANK), .CW(CW), .SB(STRIDE_BITS)) u_src_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (grp_v[MAX_RANK-1]),
		.coords    (src_coord),
		.strides   (sstr),
		.mask      (in_rank),
		.out_valid (src_v),
		.sum       (src_sum)
	);

	sicag_dot #(.N(MAX_RANK), .CW(CW), .SB(STRIDE_BITS)) u_dst_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (grp_v[MAX_RANK-1]),
		.coords    (dst_coord),
		.strides   (dstr),
		.mask      (in_rank),
		.out_valid (dst_v),
		.sum       (dst_sum)
	);

	// Flags and value follow the dot products.
	sicag_delay #(.W(FIN_W), .N(2)) u_fin (
		.clk  (clk),
		.din  ({outside_e, idx_bad_d, elem_c}),
		.dout (fin_d)
	);

	// Result register: outside has priority over a skipped index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= src_v;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= fin_d[VALUE_BITS-1:0];
		priority if (fin_d[FIN_W-1]) begin
			src_off_q <= '0;
			dst_off_q <= '0;
			status_q  <= ST_OUTSIDE;
		end else if (fin_d[FIN_W-2]) begin
			src_off_q <= src_sum;
			dst_off_q <= '0;
			status_q  <= ST_SKIP;
		end else begin
			src_off_q <= src_sum;
			dst_off_q <= dst_sum;
			status_q  <= ST_WRITE;
		end
	end

	assign done         = done_q;
	assign src_offset   = signed'(src_off_q);
	assign dst_offset   = signed'(dst_off_q);
	assign copied_value = value_q;
	assign status       = status_q;

`ifndef SYNTH
	// Every accepted item yields its result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after item transfer");

	// The two dot-product pipelines stay in step.
	a_dot_sync: assert property (@(posedge clk) disable iff (!arst_n)
		src_v == dst_v)
		else $error("dot-product pipelines out of step");

	// A position outside the source gives zero offsets.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_OUTSIDE |-> src_offset == '0 && dst_offset == '0)
		else $error("outside result with non-zero offset");

	// A skipped index gives a zero target offset.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_SKIP |-> dst_offset == '0)
		else $error("skipped index with non-zero target offset");

	// Results only leave when the source dot product delivered an item.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(src_v))
		else $error("result without a finished item");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for the strided index-copy address generator.
// Depends on sicag_pkg and strided_index_copy_address_gen; self-checking.
`timescale 1ns / 1ps

module tb import sicag_pkg::*;;

	localparam int N_DIMS    = 4;
	localparam int LATENCY   = 4 + N_DIMS * 12;
	localparam int N_RANDOM  = 1200;
	localparam longint CYCLE_LIMIT = 400000;

	// One row of the directed table; chk_exp says whether the typed result is used.
	typedef struct {
		logic [SLICE_BITS-1:0]       slice;
		logic signed [INDEX_BITS-1:0] idx;
		logic [ELEM_BITS-1:0]        elem;
		logic [VALUE_BITS-1:0]       val;
		bit                          chk_exp;
		logic [OFF_BITS-1:0]         e_src;
		logic [OFF_BITS-1:0]         e_dst;
		logic [1:0]                  e_st;
	} row_t;

	typedef struct {
		logic [OFF_BITS-1:0]   src;
		logic [OFF_BITS-1:0]   dst;
		logic [VALUE_BITS-1:0] val;
		logic [1:0]            st;
	} addr_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [SLICE_BITS-1:0] src_slice = '0;
	logic signed [INDEX_BITS-1:0] index_value = '0;
	logic [ELEM_BITS-1:0] elem_num = '0;
	logic [VALUE_BITS-1:0] elem_value = '0;
	logic done;
	logic signed [OFF_BITS-1:0] src_offset;
	logic signed [OFF_BITS-1:0] dst_offset;
	logic [VALUE_BITS-1:0] copied_value;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [PACKED_BITS-1:0] cfg_data = '0;

	// Shadow copy of the block's registers.
	logic [2:0]             m_rank;
	logic [1:0]             m_sel;
	logic [PACKED_BITS-1:0] m_ext;
	logic [PACKED_BITS-1:0] m_sstr;
	logic [PACKED_BITS-1:0] m_dstr;
	logic [DEXT_BITS-1:0]   m_dext;

	addr_res_t expected_addrs[$];
	int        n_errors = 0;
	longint    cycle_cnt = 0;

	strided_index_copy_address_gen u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.src_slice(src_slice), .index_value(index_value),
		.elem_num(elem_num), .elem_value(elem_value),
		.done(done), .src_offset(src_offset), .dst_offset(dst_offset),
		.copied_value(copied_value), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Works out the scatter addresses of one element from the shadow registers.
	function automatic addr_res_t scatter_addr(input logic [SLICE_BITS-1:0] slice,
			input logic signed [INDEX_BITS-1:0] idx, input logic [ELEM_BITS-1:0] elem,
			input logic [VALUE_BITS-1:0] val);
		addr_res_t r;
		int rk;
		int sd;
		bit outside;
		logic [63:0] rem;
		logic [63:0] crd[N_DIMS];
		logic [63:0] ext;
		logic [63:0] soff;
		logic [63:0] doff;
		r.val = val;
		rk = (m_rank == 0) ? 1 : ((m_rank > N_DIMS) ? N_DIMS : int'(m_rank));
		sd = int'(m_sel);
		outside = 1'b0;
		rem = 64'(elem);
		soff = '0;
		doff = '0;
		for (int d = 0; d < N_DIMS; d++) crd[d] = '0;
		if (sd >= rk) begin
			outside = 1'b1;
		end else begin
			if (64'(slice) >= 64'(m_ext[sd*16 +: 16])) outside = 1'b1;
			for (int d = rk - 1; d >= 0; d--) begin
				if (d != sd) begin
					ext = 64'(m_ext[d*16 +: 16]);
					if (ext == 0) begin
						outside = 1'b1;
					end else begin
						crd[d] = rem % ext;
						rem = rem / ext;
					end
				end
			end
			if (rem != 0) outside = 1'b1;
		end
		if (outside) begin
			r.src = '0;
			r.dst = '0;
			r.st = ST_OUTSIDE;
			return r;
		end
		crd[sd] = 64'(slice);
		for (int k = 0; k < rk; k++)
			soff += crd[k] * 64'(signed'(m_sstr[k*16 +: 16]));
		r.src = soff[OFF_BITS-1:0];
		if (idx < 0 || 64'(idx) >= 64'(m_dext)) begin
			r.dst = '0;
			r.st = ST_SKIP;
		end else begin
			crd[sd] = idx;
			for (int k = 0; k < rk; k++)
				doff += crd[k] * 64'(signed'(m_dstr[k*16 +: 16]));
			r.dst = doff[OFF_BITS-1:0];
			r.st = ST_WRITE;
		end
		return r;
	endfunction

	// Result checking against the oldest expectation.
	always @(posedge clk) begin
		addr_res_t e;
		if (arst_n && done) begin
			if (expected_addrs.size() == 0) begin
				$display("%0t: unexpected result src=%h dst=%h st=%0d", $time,
					src_offset, dst_offset, status);
				n_errors++;
			end else begin
				e = expected_addrs.pop_front();
				if (src_offset !== e.src) begin
					$display("%0t: src_offset expected %h actual %h", $time, e.src,
						src_offset);
					n_errors++;
				end
				if (dst_offset !== e.dst) begin
					$display("%0t: dst_offset expected %h actual %h", $time, e.dst,
						dst_offset);
					n_errors++;
				end
				if (copied_value !== e.val) begin
					$display("%0t: copied_value expected %h actual %h", $time, e.val,
						copied_value);
					n_errors++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					n_errors++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// One register write over the configuration channel.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] ri, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (ri)
			CFG_RANK:        m_rank = data[2:0];
			CFG_SEL_DIM:     m_sel = data[1:0];
			CFG_EXTENTS:     m_ext = data;
			CFG_SRC_STRIDES: m_sstr = data;
			CFG_DST_STRIDES: m_dstr = data;
			CFG_DST_EXTENT:  m_dext = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every result is in and the pipeline has drained.
	task automatic wait_idle();
		while (expected_addrs.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Drives one element transfer; called at a falling edge, leaves start high.
	task automatic send_elem(input logic [SLICE_BITS-1:0] s,
			input logic signed [INDEX_BITS-1:0] ix, input logic [ELEM_BITS-1:0] el,
			input logic [VALUE_BITS-1:0] v);
		start <= 1'b1;
		src_slice <= s;
		index_value <= ix;
		elem_num <= el;
		elem_value <= v;
		do @(posedge clk); while (busy);
		expected_addrs.push_back(scatter_addr(s, ix, el, v));
		@(negedge clk);
	endtask

	// Random configuration; small extents mostly, so elements land inside often.
	task automatic random_config(input int k);
		logic [63:0] ex;
		logic [63:0] ss;
		logic [63:0] ds;
		for (int d = 0; d < 4; d++) begin
			ex[d*16 +: 16] = ($urandom_range(0, 19) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 12));
			ss[d*16 +: 16] = 16'($urandom);
			ds[d*16 +: 16] = 16'($urandom);
		end
		if (k == 0) begin
			ex = '1;
			ss = {4{16'h7fff}};
			ds = {4{16'h8000}};
		end
		write_reg(CFG_RANK, 64'($urandom_range(0, 7)));
		write_reg(CFG_SEL_DIM, 64'($urandom_range(0, 3)));
		write_reg(CFG_EXTENTS, ex);
		write_reg(CFG_SRC_STRIDES, ss);
		write_reg(CFG_DST_STRIDES, ds);
		write_reg(CFG_DST_EXTENT, (k == 0) ? 64'hffff : 64'($urandom_range(0, 14)));
	endtask

	row_t dir_rows[$];

	initial begin
		row_t rw;
		int burst;
		int rk;
		logic [63:0] span;
		logic signed [63:0] ix;
		logic [47:0] el;
		m_rank = 3'd1;
		m_sel = 2'd0;
		m_ext = EXTENTS_RESET;
		m_sstr = '0;
		m_dstr = '0;
		m_dext = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// After reset: extent one, target extent zero, so index zero is skipped.
		dir_rows.push_back('{16'd0, 64'sd0, 48'd0, 64'h0, 1'b1, 35'd0, 35'd0, ST_SKIP});
		dir_rows.push_back('{16'd1, 64'sd0, 48'd0, '1, 1'b1, 35'd0, 35'd0, ST_OUTSIDE});
		dir_rows.push_back('{16'd0, 64'sd0, 48'd1, 64'h5a5a, 1'b1, 35'd0, 35'd0,
			ST_OUTSIDE});
		dir_rows.push_back('{'1, 64'sh7fffffffffffffff, '1, '1, 1'b1, 35'd0, 35'd0,
			ST_OUTSIDE});
		dir_rows.push_back('{16'd0, -64'sd1, 48'd0, 64'h1, 1'b1, 35'd0, 35'd0, ST_SKIP});
		foreach (dir_rows[i]) begin
			rw = dir_rows[i];
			send_elem(rw.slice, rw.idx, rw.elem, rw.val);
			expected_addrs[$].src = rw.e_src;
			expected_addrs[$].dst = rw.e_dst;
			expected_addrs[$].st = rw.e_st;
		end
		start <= 1'b0;
		wait_idle();

		// Full extents and extreme strides, rank four, dimension three selected.
		write_reg(CFG_RANK, 64'd4);
		write_reg(CFG_SEL_DIM, 64'd3);
		write_reg(CFG_EXTENTS, '1);
		write_reg(CFG_SRC_STRIDES, {4{16'h7fff}});
		write_reg(CFG_DST_STRIDES, {4{16'h8000}});
		write_reg(CFG_DST_EXTENT, 64'hffff);
		dir_rows.delete();
		dir_rows.push_back('{'1, 64'sd65534, 48'hfffe_fffe_fffe, '1, 1'b0, 35'd0, 35'd0,
			ST_WRITE});
		dir_rows.push_back('{16'd0, 64'sd0, 48'd0, 64'h0, 1'b1, 35'd0, 35'd0, ST_WRITE});
		dir_rows.push_back('{16'd3, 64'sd65535, 48'd7, 64'h1, 1'b0, 35'd0, 35'd0,
			ST_WRITE});
		dir_rows.push_back('{16'd3, 64'sh8000000000000000, 48'd7, 64'h2, 1'b0, 35'd0,
			35'd0, ST_WRITE});
		dir_rows.push_back('{16'd3, 64'sd2, 48'hffff_ffff_ffff, 64'h3, 1'b1, 35'd0,
			35'd0, ST_OUTSIDE});
		foreach (dir_rows[i]) begin
			rw = dir_rows[i];
			send_elem(rw.slice, rw.idx, rw.elem, rw.val);
			if (rw.chk_exp) begin
				expected_addrs[$].src = rw.e_src;
				expected_addrs[$].dst = rw.e_dst;
				expected_addrs[$].st = rw.e_st;
			end
		end
		start <= 1'b0;
		wait_idle();

		// Selected dimension not below rank, rank zero and rank above the maximum.
		write_reg(CFG_RANK, 64'd0);
		write_reg(CFG_SEL_DIM, 64'd2);
		send_elem(16'd0, 64'sd0, 48'd0, 64'h77);
		start <= 1'b0;
		wait_idle();
		write_reg(CFG_SEL_DIM, 64'd0);
		send_elem(16'd5, 64'sd3, 48'd0, 64'h78);
		start <= 1'b0;
		wait_idle();
		write_reg(CFG_RANK, 64'd7);
		send_elem(16'd5, 64'sd3, 48'd1234, 64'h79);
		start <= 1'b0;
		wait_idle();

		// Random phases: bursts of elements with gaps, mostly inside the source.
		for (int ph = 0; ph < 12; ph++) begin
			random_config(ph);
			rk = (m_rank == 0) ? 1 : ((m_rank > 4) ? 4 : int'(m_rank));
			span = 1;
			for (int d = 0; d < rk; d++)
				if (d != m_sel) span = span * 64'(m_ext[d*16 +: 16]);
			for (int n = 0; n < N_RANDOM / 12; ) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && n < N_RANDOM / 12; b++, n++) begin
					case ($urandom_range(0, 5))
						0: ix = {$urandom, $urandom};
						1: ix = -64'sd1 * 64'($urandom_range(1, 4));
						default: ix = 64'($urandom_range(0, int'(m_dext) + 1));
					endcase
					if ($urandom_range(0, 4) == 0 || span == 0)
						el = 48'({$urandom, $urandom});
					else
						el = 48'({$urandom, $urandom} % (span + 1));
					send_elem(($urandom_range(0, 9) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, int'(m_ext[m_sel*16 +: 16]))),
						ix, el, {$urandom, $urandom});
				end
				if ($urandom_range(0, 2) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 8)) @(negedge clk);
				end
			end
			start <= 1'b0;
			wait_idle();
		end

		if (n_errors == 0 && expected_addrs.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
